/* rtl/dccm_pkg.sv */
// dccm_pkg: shared types, fixed-point constants and register codes
// for the dominant channel color mask unit; depends on nothing
`timescale 1ns / 1ps

package dccm_pkg;

    // signed q3.frac fixed point
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 4;
    localparam int NUM_SHIFT = VAL_W - 1 - FRAC_BITS;
    localparam int SH_W      = 2 * FRAC_BITS + 2;
    localparam int ADDR_W    = 5;

    localparam logic signed [VAL_W-1:0] ONE_Q     = VAL_W'(1) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] VAL_MAX_Q = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN_Q = {1'b1, {(VAL_W-1){1'b0}}};

    // shape curve codes
    localparam logic [2:0] SPEED_POW8   = 3'd0;
    localparam logic [2:0] SPEED_POW2   = 3'd2;
    localparam logic [2:0] SPEED_LINEAR = 3'd3;
    localparam logic [2:0] SPEED_ROOT2  = 3'd4;
    localparam logic [2:0] SPEED_PASS   = 3'd7;

    // key channel codes
    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;
    localparam logic [1:0] CHAN_PASS  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_SHAPE_SPEED    = 3'd0;
    localparam logic [2:0] REG_KEY_CHANNEL    = 3'd1;
    localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_NEGATIVE_MODE  = 3'd4;
    localparam logic [2:0] REG_CHROMA_MODE    = 3'd5;
    localparam logic [2:0] REG_RELATIVE_MODE  = 3'd6;
    localparam logic [2:0] REG_INVERT_MODE    = 3'd7;

    typedef struct packed {
        logic signed [VAL_W-1:0] red_in;
        logic signed [VAL_W-1:0] green_in;
        logic signed [VAL_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] red_out;
        logic signed [VAL_W-1:0] green_out;
        logic signed [VAL_W-1:0] blue_out;
    } pixel_out_t;

    typedef struct packed {
        logic                    vld;
        logic                    pass;
        logic                    nd;
        logic                    rel;
        logic                    relsat;
        logic                    hit_hi;
        logic                    hit_lo;
        pixel_in_t               pix;
        logic signed [VAL_W-1:0] ck;
        logic signed [VAL_W-1:0] ca;
        logic signed [VAL_W-1:0] cb;
        logic [VAL_W-1:0]        val;
        logic [VAL_W:0]          rem;
        logic [VAL_W-1:0]        dvs;
        logic [VAL_W-1:0]        quo;
        logic [SH_W-1:0]         sh;
    } stage_t;

endpackage

/* rtl/dominant_channel_color_mask_unit.sv */
// dominant_channel_color_mask_unit: pipelined per-pixel color key mask
// depends on dccm_pkg for types, constants and register codes
`timescale 1ns / 1ps

// usage
//   pixels enter on s_valid/s_ready/s_data and masks leave on
//   m_valid/m_ready/m_data; each request carries one rgb triple in q3.16
//   one request a cycle is taken in steady state when not stalled, every pixel is independent
//   depth: set by the two one-bit-per-stage dividers (relative and
//   ramp) and the three chained one-bit-per-stage square root units
//   throughput: one pixel per cycle unless stalled, the whole pipe advances together
//   stall: when m_valid is high and m_ready low, the pipe freezes and
//   s_ready drops; nothing is lost or repeated, bubbles ride as invalid
//   reset (aresetn low, synchronous) clears every stage valid bit and loads
//   register defaults: speed linear, key red, low 0, high 1.0, modes off
//   config: apb write at psel & penable & pwrite, pready tied high,
//   register i at byte address 4*i; write only while the pipe is empty
//   stages: input, negation, difference, 19 relative divide steps, select,
//   ramp setup, 16 ramp divide steps, select, three squarers, three roots of
//   setup + 17 steps + select each, and the output mux with inversion
module dominant_channel_color_mask_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  dccm_pkg::pixel_in_t    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output dccm_pkg::pixel_out_t   m_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [dccm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import dccm_pkg::*;

    // stage map
    localparam int S_NEG   = 1;
    localparam int S_DIFF  = 2;
    localparam int S_RDIV0 = 3;
    localparam int S_RSEL  = S_RDIV0 + VAL_W - 1;
    localparam int S_RAMP  = S_RSEL + 1;
    localparam int S_QDIV0 = S_RAMP + 1;
    localparam int S_QSEL  = S_QDIV0 + FRAC_BITS;
    localparam int S_SQ0   = S_QSEL + 1;
    localparam int S_RT0   = S_SQ0 + 3;
    localparam int RT_LEN  = FRAC_BITS + 3;
    localparam int S_OUT   = S_RT0 + 3 * RT_LEN;
    localparam int NS      = S_OUT + 1;

    // configuration registers
    logic [2:0]              shape_speed_reg;
    logic [1:0]              key_channel_reg;
    logic signed [VAL_W-1:0] low_threshold_reg;
    logic signed [VAL_W-1:0] high_threshold_reg;
    logic                    negative_mode_reg;
    logic                    chroma_mode_reg;
    logic                    relative_mode_reg;
    logic                    invert_mode_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_speed_reg    <= SPEED_LINEAR;
            key_channel_reg    <= CHAN_RED;
            low_threshold_reg  <= '0;
            high_threshold_reg <= ONE_Q;
            negative_mode_reg  <= 1'b0;
            chroma_mode_reg    <= 1'b0;
            relative_mode_reg  <= 1'b0;
            invert_mode_reg    <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SHAPE_SPEED:    shape_speed_reg    <= pwdata[2:0];
                REG_KEY_CHANNEL:    key_channel_reg    <= pwdata[1:0];
                REG_LOW_THRESHOLD:  low_threshold_reg  <= pwdata[VAL_W-1:0];
                REG_HIGH_THRESHOLD: high_threshold_reg <= pwdata[VAL_W-1:0];
                REG_NEGATIVE_MODE:  negative_mode_reg  <= pwdata[0];
                REG_CHROMA_MODE:    chroma_mode_reg    <= pwdata[0];
                REG_RELATIVE_MODE:  relative_mode_reg  <= pwdata[0];
                REG_INVERT_MODE:    invert_mode_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SHAPE_SPEED:    prdata = 32'(shape_speed_reg);
            REG_KEY_CHANNEL:    prdata = 32'(key_channel_reg);
            REG_LOW_THRESHOLD:  prdata = 32'(low_threshold_reg);
            REG_HIGH_THRESHOLD: prdata = 32'(high_threshold_reg);
            REG_NEGATIVE_MODE:  prdata = 32'(negative_mode_reg);
            REG_CHROMA_MODE:    prdata = 32'(chroma_mode_reg);
            REG_RELATIVE_MODE:  prdata = 32'(relative_mode_reg);
            REG_INVERT_MODE:    prdata = 32'(invert_mode_reg);
            default:            prdata = '0;
        endcase
    end

    // one minus x, saturated
    function automatic logic signed [VAL_W-1:0] neg_sat(input logic signed [VAL_W-1:0] x);
        logic signed [VAL_W:0] s;
        begin
            s = $signed({ONE_Q[VAL_W-1], ONE_Q}) - $signed({x[VAL_W-1], x});
            if (s > $signed({VAL_MAX_Q[VAL_W-1], VAL_MAX_Q}))
                neg_sat = VAL_MAX_Q;
            else if (s < $signed({VAL_MIN_Q[VAL_W-1], VAL_MIN_Q}))
                neg_sat = VAL_MIN_Q;
            else
                neg_sat = s[VAL_W-1:0];
        end
    endfunction

    // pipeline
    stage_t pipe_reg  [NS];
    stage_t stg_next  [NS];
    logic   adv;

    assign adv     = !pipe_reg[NS-1].vld || m_ready;
    assign s_ready = adv;
    assign m_valid = pipe_reg[NS-1].vld;
    assign m_data  = pixel_out_t'(pipe_reg[NS-1].pix);

    always_comb begin
        stg_next[0]      = '0;
        stg_next[0].vld  = s_valid;
        stg_next[0].pix  = s_data;
        stg_next[0].pass = (shape_speed_reg == SPEED_PASS) ||
                           (key_channel_reg == CHAN_PASS) ||
                           (low_threshold_reg > high_threshold_reg);
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        localparam int RJ = (k - S_RT0) / RT_LEN;
        localparam int RP = (k - S_RT0) % RT_LEN;

        always_comb begin
            logic signed [VAL_W-1:0] cr, cg, cbl, mid, mn, sub, mm;
            logic signed [VAL_W:0]   sw;
            logic [VAL_W-1:0]        d;
            logic [VAL_W+1:0]        t;
            logic [VAL_W:0]          trial;
            logic [2*FRAC_BITS+1:0]  prod;

            stg_next[k] = pipe_reg[k-1];
            cr = '0; cg = '0; cbl = '0; mid = '0; mn = '0; sub = '0; mm = '0;
            sw = '0; d = '0; t = '0; trial = '0; prod = '0;

            if (k == S_NEG) begin
                cr  = pipe_reg[k-1].pix.red_in;
                cg  = pipe_reg[k-1].pix.green_in;
                cbl = pipe_reg[k-1].pix.blue_in;
                if (negative_mode_reg) begin
                    cr  = neg_sat(cr);
                    cg  = neg_sat(cg);
                    cbl = neg_sat(cbl);
                end
                case (key_channel_reg)
                    CHAN_GREEN: begin
                        stg_next[k].ck = cg;  stg_next[k].ca = cr; stg_next[k].cb = cbl;
                    end
                    CHAN_BLUE: begin
                        stg_next[k].ck = cbl; stg_next[k].ca = cr; stg_next[k].cb = cg;
                    end
                    default: begin
                        stg_next[k].ck = cr;  stg_next[k].ca = cg; stg_next[k].cb = cbl;
                    end
                endcase
            end else if (k == S_DIFF) begin
                // dominance test and key minus mid or min
                stg_next[k].nd = !(pipe_reg[k-1].ck > pipe_reg[k-1].ca &&
                                   pipe_reg[k-1].ck > pipe_reg[k-1].cb);
                if (pipe_reg[k-1].ca >= pipe_reg[k-1].cb) begin
                    mid = pipe_reg[k-1].ca; mn = pipe_reg[k-1].cb;
                end else begin
                    mid = pipe_reg[k-1].cb; mn = pipe_reg[k-1].ca;
                end
                sub = chroma_mode_reg ? mn : mid;
                sw  = $signed({pipe_reg[k-1].ck[VAL_W-1], pipe_reg[k-1].ck}) -
                      $signed({sub[VAL_W-1], sub});
                if (sw > $signed({VAL_MAX_Q[VAL_W-1], VAL_MAX_Q}))
                    d = VAL_MAX_Q;
                else if (sw < $signed({VAL_MIN_Q[VAL_W-1], VAL_MIN_Q}))
                    d = VAL_MIN_Q;
                else
                    d = sw[VAL_W-1:0];
                stg_next[k].val    = d;
                stg_next[k].dvs    = pipe_reg[k-1].ck;
                stg_next[k].rel    = relative_mode_reg && (pipe_reg[k-1].ck > 0);
                // quotient overflows once d reaches the key value scaled up by NUM_SHIFT bits
                stg_next[k].relsat = {{NUM_SHIFT{1'b0}}, d} >=
                                     {pipe_reg[k-1].ck, {NUM_SHIFT{1'b0}}};
                stg_next[k].rem    = (VAL_W+1)'(d >> NUM_SHIFT);
                stg_next[k].quo    = '0;
                stg_next[k].sh     = '0;
                stg_next[k].sh[SH_W-1 -: VAL_W-1] = {d[NUM_SHIFT-1:0], {FRAC_BITS{1'b0}}};
            end else if (k >= S_RDIV0 && k < S_RSEL) begin
                // restoring divide step, one quotient bit
                t = {1'b0, pipe_reg[k-1].rem[VAL_W-1:0], pipe_reg[k-1].sh[SH_W-1]};
                stg_next[k].sh = pipe_reg[k-1].sh << 1;
                if (t >= {2'b00, pipe_reg[k-1].dvs}) begin
                    stg_next[k].rem = (VAL_W+1)'(t - {2'b00, pipe_reg[k-1].dvs});
                    stg_next[k].quo = {pipe_reg[k-1].quo[VAL_W-2:0], 1'b1};
                end else begin
                    stg_next[k].rem = t[VAL_W:0];
                    stg_next[k].quo = {pipe_reg[k-1].quo[VAL_W-2:0], 1'b0};
                end
            end else if (k == S_RSEL) begin
                if (pipe_reg[k-1].rel)
                    stg_next[k].val = pipe_reg[k-1].relsat ? VAL_MAX_Q : pipe_reg[k-1].quo;
            end else if (k == S_RAMP) begin
                stg_next[k].hit_hi = $signed(pipe_reg[k-1].val) >= high_threshold_reg;
                stg_next[k].hit_lo = $signed(pipe_reg[k-1].val) <= low_threshold_reg;
                sw = $signed({pipe_reg[k-1].val[VAL_W-1], pipe_reg[k-1].val}) -
                     $signed({low_threshold_reg[VAL_W-1], low_threshold_reg});
                stg_next[k].rem = sw;
                sw = $signed({high_threshold_reg[VAL_W-1], high_threshold_reg}) -
                     $signed({low_threshold_reg[VAL_W-1], low_threshold_reg});
                stg_next[k].dvs = sw[VAL_W-1:0];
                stg_next[k].quo = '0;
            end else if (k >= S_QDIV0 && k < S_QSEL) begin
                t = {pipe_reg[k-1].rem, 1'b0};
                if (t >= {2'b00, pipe_reg[k-1].dvs}) begin
                    stg_next[k].rem = (VAL_W+1)'(t - {2'b00, pipe_reg[k-1].dvs});
                    stg_next[k].quo = {pipe_reg[k-1].quo[VAL_W-2:0], 1'b1};
                end else begin
                    stg_next[k].rem = t[VAL_W:0];
                    stg_next[k].quo = {pipe_reg[k-1].quo[VAL_W-2:0], 1'b0};
                end
            end else if (k == S_QSEL) begin
                if (pipe_reg[k-1].hit_hi)
                    stg_next[k].val = ONE_Q;
                else if (pipe_reg[k-1].hit_lo)
                    stg_next[k].val = '0;
                else
                    stg_next[k].val = pipe_reg[k-1].quo;
            end else if (k >= S_SQ0 && k < S_RT0) begin
                // squarer, used by the power curves
                if (shape_speed_reg <= 3'(SPEED_POW2 - 3'(k - S_SQ0))) begin
                    prod = pipe_reg[k-1].val[FRAC_BITS:0] * pipe_reg[k-1].val[FRAC_BITS:0];
                    stg_next[k].val = VAL_W'(prod[2*FRAC_BITS+1:FRAC_BITS]);
                end
            end else if (k >= S_RT0 && k < S_OUT) begin
                if (RP == 0) begin
                    stg_next[k].rem = '0;
                    stg_next[k].quo = '0;
                    stg_next[k].sh  = {1'b0, pipe_reg[k-1].val[FRAC_BITS:0],
                                       {FRAC_BITS{1'b0}}};
                end else if (RP <= FRAC_BITS + 1) begin
                    // digit-by-digit square root, two radicand bits per step
                    t     = {1'b0, pipe_reg[k-1].rem[VAL_W-2:0],
                             pipe_reg[k-1].sh[SH_W-1 -: 2]};
                    trial = {pipe_reg[k-1].quo[VAL_W-2:0], 2'b01};
                    stg_next[k].sh = pipe_reg[k-1].sh << 2;
                    if (t >= {1'b0, trial}) begin
                        stg_next[k].rem = (VAL_W+1)'(t - {1'b0, trial});
                        stg_next[k].quo = {pipe_reg[k-1].quo[VAL_W-2:0], 1'b1};
                    end else begin
                        stg_next[k].rem = t[VAL_W:0];
                        stg_next[k].quo = {pipe_reg[k-1].quo[VAL_W-2:0], 1'b0};
                    end
                end else begin
                    if (shape_speed_reg >= 3'(SPEED_ROOT2 + 3'(RJ)))
                        stg_next[k].val = pipe_reg[k-1].quo;
                end
            end else begin
                // output mux with inversion
                mm = pipe_reg[k-1].nd ? '0 : $signed(pipe_reg[k-1].val);
                if (invert_mode_reg)
                    mm = ONE_Q - mm;
                if (!pipe_reg[k-1].pass) begin
                    stg_next[k].pix.red_in   = mm;
                    stg_next[k].pix.green_in = mm;
                    stg_next[k].pix.blue_in  = mm;
                end
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pipe_reg[k].vld <= 1'b0;
            end else if (adv) begin
                pipe_reg[k] <= stg_next[k];
            end
        end
    end

endmodule
